[rtl/tekd_pkg.sv]
package tekd_pkg;

	localparam int CP_W = 21;

	// characters of interest
	localparam logic [CP_W-1:0] CH_ESC   = 21'd27;
	localparam logic [CP_W-1:0] CH_LBRK  = 21'd91;   // '['
	localparam logic [CP_W-1:0] CH_SS3   = 21'd79;   // 'O'
	localparam logic [CP_W-1:0] CH_SEMI  = 21'd59;   // ';'
	localparam logic [CP_W-1:0] CH_TILDE = 21'd126;  // '~'
	localparam logic [CP_W-1:0] CH_ZERO  = 21'd48;
	localparam logic [CP_W-1:0] CH_NINE  = 21'd57;

	localparam logic [5:0]  MAX_SEQ    = 6'd32;
	localparam logic [2:0]  MAX_DIGITS = 3'd5;
	localparam logic [14:0] VALUE_CAP  = 15'd32767;
	localparam logic [14:0] TILDE_MAX  = 15'd24;
	localparam logic [5:0]  SS3_ENTRIES = 6'd3;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_ESC  = 2'd1,
		MODE_SEQ  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_KEY  = 2'd1,
		KIND_DROP = 2'd2
	} kind_t;

	localparam logic [4:0] KEY_UP     = 5'd0;
	localparam logic [4:0] KEY_DOWN   = 5'd1;
	localparam logic [4:0] KEY_RIGHT  = 5'd2;
	localparam logic [4:0] KEY_LEFT   = 5'd3;
	localparam logic [4:0] KEY_HOME   = 5'd4;
	localparam logic [4:0] KEY_END    = 5'd5;
	localparam logic [4:0] KEY_DELETE = 5'd6;
	localparam logic [4:0] KEY_F1     = 5'd7;

	typedef struct packed {
		logic       hit;
		logic [4:0] key;
	} key_lookup_t;

	typedef struct packed {
		kind_t           kind;
		logic [CP_W-1:0] char_value;
		logic [4:0]      named_key;
		logic            last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} step_out_t;

	function automatic key_lookup_t mk_key(input logic [4:0] k);
		key_lookup_t r;
		r.hit = 1'b1;
		r.key = k;
		return r;
	endfunction

	function automatic key_lookup_t ss3_key(input logic [CP_W-1:0] c);
		key_lookup_t r;
		r = '0;
		case (c)
			21'd65:  r = mk_key(KEY_UP);        // A
			21'd66:  r = mk_key(KEY_DOWN);      // B
			21'd67:  r = mk_key(KEY_RIGHT);     // C
			21'd68:  r = mk_key(KEY_LEFT);      // D
			21'd70:  r = mk_key(KEY_END);       // F
			21'd72:  r = mk_key(KEY_HOME);      // H
			21'd80:  r = mk_key(KEY_F1);        // P
			21'd81:  r = mk_key(KEY_F1 + 5'd1); // Q
			21'd82:  r = mk_key(KEY_F1 + 5'd2); // R
			21'd83:  r = mk_key(KEY_F1 + 5'd3); // S
			21'd116: r = mk_key(KEY_F1 + 5'd4); // t
			21'd117: r = mk_key(KEY_F1 + 5'd5); // u
			21'd118: r = mk_key(KEY_F1 + 5'd6); // v
			21'd108: r = mk_key(KEY_F1 + 5'd7); // l
			21'd119: r = mk_key(KEY_F1 + 5'd8); // w
			21'd120: r = mk_key(KEY_F1 + 5'd9); // x
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic key_lookup_t tilde_key(input logic [4:0] p);
		key_lookup_t r;
		r = '0;
		case (p)
			5'd1:    r = mk_key(KEY_HOME);
			5'd3:    r = mk_key(KEY_DELETE);
			5'd4:    r = mk_key(KEY_END);
			5'd7:    r = mk_key(KEY_HOME);
			5'd11:   r = mk_key(KEY_F1);
			5'd12:   r = mk_key(KEY_F1 + 5'd1);
			5'd13:   r = mk_key(KEY_F1 + 5'd2);
			5'd14:   r = mk_key(KEY_F1 + 5'd3);
			5'd15:   r = mk_key(KEY_F1 + 5'd4);
			5'd17:   r = mk_key(KEY_F1 + 5'd5);
			5'd18:   r = mk_key(KEY_F1 + 5'd6);
			5'd19:   r = mk_key(KEY_F1 + 5'd7);
			5'd20:   r = mk_key(KEY_F1 + 5'd8);
			5'd21:   r = mk_key(KEY_F1 + 5'd9);
			5'd23:   r = mk_key(KEY_F1 + 5'd10);
			5'd24:   r = mk_key(KEY_F1 + 5'd11);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic key_lookup_t csi_key(input logic [CP_W-1:0] c, input logic [14:0] fp);
		key_lookup_t r;
		r = '0;
		case (c)
			21'd65:  r = mk_key(KEY_UP);
			21'd66:  r = mk_key(KEY_DOWN);
			21'd67:  r = mk_key(KEY_RIGHT);
			21'd68:  r = mk_key(KEY_LEFT);
			21'd72:  r = mk_key(KEY_HOME);
			21'd70:  r = mk_key(KEY_END);
			CH_TILDE: r = (fp <= TILDE_MAX) ? tilde_key(fp[4:0]) : '0;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/tekd_parser.sv]
module tekd_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [tekd_pkg::CP_W-1:0]     code_point,
	input  logic                          no_char,
	output tekd_pkg::step_out_t           res
);

	tekd_pkg::mode_t mode_q, mode_d;
	logic        ss3_q, ss3_d;
	logic [2:0]  dcnt_q, dcnt_d;
	logic [16:0] cval_q, cval_d;
	logic [14:0] fparam_q, fparam_d;
	logic [5:0]  ecnt_q, ecnt_d;

	logic        is_digit;
	logic [20:0] cval_mul;
	logic [14:0] pval;
	logic [14:0] fp_new;
	logic [5:0]  ecnt_1, ecnt_2;
	tekd_pkg::key_lookup_t lk;
	tekd_pkg::result_t     esc_r, chr_r, drop_r, key_r;

	assign is_digit = (code_point >= tekd_pkg::CH_ZERO) && (code_point <= tekd_pkg::CH_NINE);
	assign cval_mul = ({4'd0, cval_q} << 3) + ({4'd0, cval_q} << 1) + {17'd0, code_point[3:0]};

	// parameter value: empty/zero defaults to 1, saturate at cap
	always_comb begin
		if (cval_q == 17'd0)
			pval = 15'd1;
		else if (cval_q > {2'd0, tekd_pkg::VALUE_CAP})
			pval = tekd_pkg::VALUE_CAP;
		else
			pval = cval_q[14:0];
	end

	assign fp_new = (ecnt_q == 6'd1) ? pval : fparam_q;
	assign ecnt_1 = (ecnt_q < tekd_pkg::MAX_SEQ) ? ecnt_q + 6'd1 : ecnt_q;
	assign ecnt_2 = (ecnt_1 < tekd_pkg::MAX_SEQ) ? ecnt_1 + 6'd1 : ecnt_1;

	always_comb begin
		lk = '0;
		if (ecnt_2 < tekd_pkg::MAX_SEQ) begin
			if (ss3_q)
				lk = (ecnt_2 == tekd_pkg::SS3_ENTRIES) ? tekd_pkg::ss3_key(code_point) : '0;
			else
				lk = tekd_pkg::csi_key(code_point, fp_new);
		end
	end

	always_comb begin
		esc_r = '0;
		esc_r.kind = tekd_pkg::KIND_CHAR;
		esc_r.char_value = tekd_pkg::CH_ESC;
		esc_r.last = 1'b1;
		chr_r = '0;
		chr_r.kind = tekd_pkg::KIND_CHAR;
		chr_r.char_value = code_point;
		chr_r.last = 1'b1;
		drop_r = '0;
		drop_r.kind = tekd_pkg::KIND_DROP;
		drop_r.last = 1'b1;
		key_r = '0;
		key_r.kind = tekd_pkg::KIND_KEY;
		key_r.named_key = lk.key;
		key_r.last = 1'b1;
	end

	always_comb begin
		mode_d   = tekd_pkg::MODE_IDLE;
		ss3_d    = ss3_q;
		dcnt_d   = dcnt_q;
		cval_d   = cval_q;
		fparam_d = fparam_q;
		ecnt_d   = ecnt_q;
		res      = '0;
		unique case (mode_q)
			tekd_pkg::MODE_ESC: begin
				if (no_char || code_point == tekd_pkg::CH_ESC) begin
					res.n  = 2'd1;
					res.r0 = esc_r;
				end else if (code_point == tekd_pkg::CH_LBRK || code_point == tekd_pkg::CH_SS3) begin
					mode_d   = tekd_pkg::MODE_SEQ;
					ss3_d    = (code_point == tekd_pkg::CH_SS3);
					dcnt_d   = 3'd0;
					cval_d   = 17'd0;
					fparam_d = 15'd0;
					ecnt_d   = 6'd1;
				end else begin
					res.n  = 2'd2;
					res.r0 = esc_r;
					res.r0.last = 1'b0;
					res.r1 = chr_r;
				end
			end
			tekd_pkg::MODE_SEQ: begin
				if (no_char) begin
					res.n  = 2'd1;
					res.r0 = drop_r;
				end else if (is_digit) begin
					mode_d = tekd_pkg::MODE_SEQ;
					if (dcnt_q < tekd_pkg::MAX_DIGITS) begin
						cval_d = cval_mul[16:0];
						dcnt_d = dcnt_q + 3'd1;
					end
				end else begin
					fparam_d = fp_new;
					dcnt_d   = 3'd0;
					cval_d   = 17'd0;
					if (code_point == tekd_pkg::CH_SEMI) begin
						mode_d = tekd_pkg::MODE_SEQ;
						ecnt_d = ecnt_1;
					end else begin
						ecnt_d = ecnt_2;
						res.n  = 2'd1;
						res.r0 = lk.hit ? key_r : drop_r;
					end
				end
			end
			default: begin
				if (!no_char) begin
					if (code_point == tekd_pkg::CH_ESC) begin
						mode_d = tekd_pkg::MODE_ESC;
					end else begin
						res.n  = 2'd1;
						res.r0 = chr_r;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tekd_pkg::MODE_IDLE;
			ss3_q    <= 1'b0;
			dcnt_q   <= 3'd0;
			cval_q   <= 17'd0;
			fparam_q <= 15'd0;
			ecnt_q   <= 6'd0;
		end else if (step) begin
			mode_q   <= mode_d;
			ss3_q    <= ss3_d;
			dcnt_q   <= dcnt_d;
			cval_q   <= cval_d;
			fparam_q <= fparam_d;
			ecnt_q   <= ecnt_d;
		end
	end

endmodule

[rtl/terminal_escape_key_decoder.sv]
// Terminal escape-sequence key decoder.
// Input channel s_axis: one received code point per word in tdata, tuser high
// for a poll with no character. Output channel m_axis: decoded words with
// kind, char_value and named_key in tdata; tlast marks the final word caused
// by one input word. An input word causes zero, one or two output words.
// An accepted input word is first held in the input register, then decoded
// into the result buffer once that has room; its first result is presented
// from the head of the buffer.
// Throughput: one input word per cycle while each causes at most one result
// and the receiver is ready; a word causing two results (escape followed by
// an ordinary character) holds the input while the second result drains.
// The rate is set by the two-entry result buffer, which a new word may
// refill only once it has, or is about to, run empty.
// When the receiver stalls, the result buffer and then the input register
// fill and s_axis_tready falls; nothing is lost.
// Reset clears the parser to idle and empties both registers.
module terminal_escape_key_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
	input  logic        s_axis_tuser,   // [0] no_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [1:0] kind, [22:2] char_value,
	                                    // [27:23] named_key, [31:28] zero
	output logic        m_axis_tlast    // last
);

	logic                          valid_s1;
	logic [tekd_pkg::CP_W-1:0]     cp_s1;
	logic                          nc_s1;
	logic [1:0]                    cnt_q;
	tekd_pkg::result_t             head_q, tail_q;
	tekd_pkg::step_out_t           res;
	logic                          consume, pop;

	assign pop     = m_axis_tvalid && m_axis_tready;
	assign consume = valid_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && m_axis_tready));
	assign s_axis_tready = !valid_s1 || consume;

	tekd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (consume),
		.code_point (cp_s1),
		.no_char    (nc_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (consume)
				cnt_q <= res.n;
			else if (pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cp_s1 <= s_axis_tdata[tekd_pkg::CP_W-1:0];
			nc_s1 <= s_axis_tuser;
		end
		if (consume) begin
			head_q <= res.r0;
			tail_q <= res.r1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = {4'd0, head_q.named_key, head_q.char_value, head_q.kind};
	assign m_axis_tlast  = head_q.last;

endmodule

[rtl/tekd_checker.sv]
module tekd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("unused kind code");

	// keys and dropped sequences carry no character
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != tekd_pkg::KIND_CHAR |->
			m_axis_tdata[22:2] == 21'd0)
		else $error("character field set on non-character word");

	// only a leading escape is ever followed by a second word
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |->
			m_axis_tdata[1:0] == tekd_pkg::KIND_CHAR && m_axis_tdata[22:2] == tekd_pkg::CH_ESC)
		else $error("non-final word is not an escape");

	// after a non-final word is taken, the next word closes the input
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
		else $error("second word of a pair missing");

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
